FILE: rtl/smx_pkg.sv
// ----------------------------------------------------------------------------
// smx_pkg
// Types and constants shared by the stack machine executor and its divider.
// ----------------------------------------------------------------------------
package smx_pkg;

   localparam int DATA_W    = 32;
   localparam int FIELD_W   = 30;
   localparam int DIV_STEPS = DATA_W;

   // Instruction header values that push a literal. Every other header
   // selects a primitive.
   localparam logic [1:0] HDR_PUSH     = 2'b00;
   localparam logic [1:0] HDR_PUSH_NEG = 2'b10;

   typedef enum logic [2:0] {
      PRIM_HALT    = 3'd0,
      PRIM_ADD     = 3'd1,
      PRIM_SUB     = 3'd2,
      PRIM_MUL     = 3'd3,
      PRIM_DIV     = 3'd4,
      PRIM_MOD     = 3'd5,
      PRIM_PRN_NUM = 3'd6,
      PRIM_PRN_CHR = 3'd7
   } prim_type;

   typedef enum logic [2:0] {
      EV_NONE      = 3'd0,
      EV_PRINT_NUM = 3'd1,
      EV_PRINT_CHR = 3'd2,
      EV_HALTED    = 3'd3,
      EV_DIV_ZERO  = 3'd4,
      EV_UNDERFLOW = 3'd5,
      EV_OVERFLOW  = 3'd6,
      EV_IGNORED   = 3'd7
   } event_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_DIV_WAIT,
      S_WRITE,
      S_RESULT
   } state_type;

endpackage

FILE: rtl/smx_divider.sv
// ----------------------------------------------------------------------------
// smx_divider
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module smx_divider (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [smx_pkg::DATA_W-1:0] dividend,
   input  logic [smx_pkg::DATA_W-1:0] divisor,
   output logic                       done,
   output logic [smx_pkg::DATA_W-1:0] quotient,
   output logic [smx_pkg::DATA_W-1:0] remainder
);

   localparam int W     = smx_pkg::DATA_W;
   localparam int STEPS = smx_pkg::DIV_STEPS;
   localparam int CNT_W = $clog2(STEPS);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [W-1:0]     quo_ff, quo_in;
   logic [W-1:0]     rem_ff, rem_in;
   logic [W-1:0]     dvs_ff, dvs_in;
   logic [W:0]       shifted;
   logic [W:0]       diff;

   always_comb begin
      shifted = {rem_ff, quo_ff[W-1]};
      diff    = shifted - {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         // The partial remainder stays below the divisor, so a non-negative
         // difference always fits back into W bits.
         if (!diff[W]) begin
            rem_in = diff[W-1:0];
         end else begin
            rem_in = shifted[W-1:0];
         end
         quo_in = {quo_ff[W-2:0], !diff[W]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

FILE: rtl/stack_machine_executor_unit.sv
// ----------------------------------------------------------------------------
// stack_machine_executor_unit
// Executes a stream of 32-bit stack machine instruction words.
// ----------------------------------------------------------------------------
// Each accepted instruction word produces exactly one result word. The block
// works on one instruction at a time: pushes, halt, unknown primitives and the
// overflow, underflow and ignored cases skip to the result state; prints
// and division by zero pass execute first; add, sub and mul pass execute and
// write-back; div and mod also wait for the 32-step divider, which produces
// one quotient bit per cycle. The stack is a memory of STACK_DEPTH words with
// one write port and two registered read ports that always present the top
// two entries. A finished result waits in an output register, so the next
// instruction is taken while that word is still pending on the result channel.
module stack_machine_executor_unit #(
   parameter int STACK_DEPTH = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [31:0]        req_instruction,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_event_kind,
   output logic signed [31:0] rsp_event_value
);

   localparam int W      = smx_pkg::DATA_W;
   localparam int FW     = smx_pkg::FIELD_W;
   localparam int ADDR_W = $clog2(STACK_DEPTH);
   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);

   smx_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               halted_ff, halted_in;
   smx_pkg::prim_type  op_ff, op_in;
   smx_pkg::event_type kind_ff, kind_in;
   logic [W-1:0]       value_ff, value_in;
   logic [W-1:0]       res_ff, res_in;
   logic               neg_q_ff, neg_q_in;
   logic               neg_r_ff, neg_r_in;

   logic               rsp_valid_ff, rsp_valid_in;
   smx_pkg::event_type rsp_kind_ff, rsp_kind_in;
   logic [W-1:0]       rsp_value_ff, rsp_value_in;

   logic [W-1:0]       stack_mem [STACK_DEPTH];
   logic [W-1:0]       rd_a_ff;
   logic [W-1:0]       rd_b_ff;
   logic [CNT_W-1:0]   cnt_m1;
   logic [CNT_W-1:0]   cnt_m2;
   logic               mem_we;
   logic [ADDR_W-1:0]  mem_waddr;
   logic [W-1:0]       mem_wdata;

   logic [1:0]         hdr;
   logic [FW-1:0]      dat;
   logic [W-1:0]       push_value;

   logic               div_start;
   logic               div_done;
   logic [W-1:0]       div_quo;
   logic [W-1:0]       div_rem;
   logic [W-1:0]       mag_a;
   logic [W-1:0]       mag_b;

   assign hdr    = req_instruction[31:30];
   assign dat    = req_instruction[FW-1:0];
   assign cnt_m1 = count_ff - CNT_W'(1);
   assign cnt_m2 = count_ff - CNT_W'(2);
   assign mag_a  = rd_a_ff[W-1] ? (W'(0) - rd_a_ff) : rd_a_ff;
   assign mag_b  = rd_b_ff[W-1] ? (W'(0) - rd_b_ff) : rd_b_ff;
   assign push_value = (hdr == smx_pkg::HDR_PUSH_NEG) ? (W'(0) - {2'b00, dat})
                                                      : {2'b00, dat};

   smx_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (mag_a),
      .divisor   (mag_b),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      halted_in    = halted_ff;
      op_in        = op_ff;
      kind_in      = kind_ff;
      value_in     = value_ff;
      res_in       = res_ff;
      neg_q_in     = neg_q_ff;
      neg_r_in     = neg_r_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_value_in = rsp_value_ff;
      mem_we       = 1'b0;
      mem_waddr    = count_ff[ADDR_W-1:0];
      mem_wdata    = push_value;
      div_start    = 1'b0;
      req_ready    = 1'b0;

      case (state_ff)
         smx_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               kind_in  = smx_pkg::EV_NONE;
               value_in = '0;
               op_in    = smx_pkg::prim_type'(dat[2:0]);
               state_in = smx_pkg::S_RESULT;
               if (halted_ff) begin
                  kind_in = smx_pkg::EV_IGNORED;
               end else begin
                  case (hdr)
                     smx_pkg::HDR_PUSH, smx_pkg::HDR_PUSH_NEG: begin
                        if (count_ff == CNT_W'(STACK_DEPTH)) begin
                           kind_in = smx_pkg::EV_OVERFLOW;
                        end else begin
                           mem_we   = 1'b1;
                           count_in = count_ff + CNT_W'(1);
                        end
                     end
                     default: begin
                        // Codes of eight and above are unknown and do nothing.
                        if (dat[FW-1:3] == '0) begin
                           case (smx_pkg::prim_type'(dat[2:0])) inside
                              smx_pkg::PRIM_HALT: begin
                                 halted_in = 1'b1;
                                 kind_in   = smx_pkg::EV_HALTED;
                              end
                              [smx_pkg::PRIM_ADD:smx_pkg::PRIM_MOD]: begin
                                 if (count_ff < CNT_W'(2)) begin
                                    kind_in = smx_pkg::EV_UNDERFLOW;
                                 end else begin
                                    state_in = smx_pkg::S_EXEC;
                                 end
                              end
                              default: begin
                                 if (count_ff == '0) begin
                                    kind_in = smx_pkg::EV_UNDERFLOW;
                                 end else begin
                                    state_in = smx_pkg::S_EXEC;
                                 end
                              end
                           endcase
                        end
                     end
                  endcase
               end
            end
         end

         smx_pkg::S_EXEC: begin
            // The read ports have caught the top two entries by now.
            state_in = smx_pkg::S_WRITE;
            case (op_ff)
               smx_pkg::PRIM_ADD: res_in = rd_a_ff + rd_b_ff;
               smx_pkg::PRIM_SUB: res_in = rd_a_ff - rd_b_ff;
               smx_pkg::PRIM_MUL: res_in = rd_a_ff * rd_b_ff;
               smx_pkg::PRIM_DIV, smx_pkg::PRIM_MOD: begin
                  if (rd_b_ff == '0) begin
                     kind_in  = smx_pkg::EV_DIV_ZERO;
                     state_in = smx_pkg::S_RESULT;
                  end else begin
                     div_start = 1'b1;
                     neg_q_in  = rd_a_ff[W-1] ^ rd_b_ff[W-1];
                     neg_r_in  = rd_a_ff[W-1];
                     state_in  = smx_pkg::S_DIV_WAIT;
                  end
               end
               smx_pkg::PRIM_PRN_NUM: begin
                  kind_in  = smx_pkg::EV_PRINT_NUM;
                  value_in = rd_b_ff;
                  state_in = smx_pkg::S_RESULT;
               end
               smx_pkg::PRIM_PRN_CHR: begin
                  kind_in  = smx_pkg::EV_PRINT_CHR;
                  value_in = {{(W-8){1'b0}}, rd_b_ff[7:0]};
                  state_in = smx_pkg::S_RESULT;
               end
               default: state_in = smx_pkg::S_RESULT;
            endcase
         end

         smx_pkg::S_DIV_WAIT: begin
            if (div_done) begin
               if (op_ff == smx_pkg::PRIM_DIV) begin
                  res_in = neg_q_ff ? (W'(0) - div_quo) : div_quo;
               end else begin
                  res_in = neg_r_ff ? (W'(0) - div_rem) : div_rem;
               end
               state_in = smx_pkg::S_WRITE;
            end
         end

         smx_pkg::S_WRITE: begin
            mem_we    = 1'b1;
            mem_waddr = cnt_m2[ADDR_W-1:0];
            mem_wdata = res_ff;
            count_in  = cnt_m1;
            state_in  = smx_pkg::S_RESULT;
         end

         smx_pkg::S_RESULT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = kind_ff;
               rsp_value_in = value_ff;
               state_in     = smx_pkg::S_IDLE;
            end
         end

         default: state_in = smx_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= smx_pkg::S_IDLE;
         count_ff     <= '0;
         halted_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         halted_ff    <= halted_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff        <= op_in;
      kind_ff      <= kind_in;
      value_ff     <= value_in;
      res_ff       <= res_in;
      neg_q_ff     <= neg_q_in;
      neg_r_ff     <= neg_r_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_value_ff <= rsp_value_in;
   end

   // Stack memory: one write port, two registered read ports on the top two
   // entries. Items run one at a time, yet a read can meet a write to its address.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         stack_mem[mem_waddr] <= mem_wdata;
      end
      rd_a_ff <= stack_mem[cnt_m2[ADDR_W-1:0]];
      rd_b_ff <= stack_mem[cnt_m1[ADDR_W-1:0]];
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_event_kind  = rsp_kind_ff;
   assign rsp_event_value = $signed(rsp_value_ff);

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(STACK_DEPTH))
      else $error("stack count beyond depth");

   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> halted_ff)
      else $error("halted state left without reset");

   a_div_done_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == smx_pkg::S_DIV_WAIT)
      else $error("divider finished outside of a division");

   a_write_two: assert property (@(posedge clock) disable iff (reset)
      state_ff == smx_pkg::S_WRITE |-> count_ff >= CNT_W'(2))
      else $error("binary result written with fewer than two entries");

endmodule
